// ===== design/sem_pkg.sv =====
// Package for the Sobel edge magnitude unit: shared types and constants.
// No dependencies.
package sem_pkg;
  localparam int unsigned PixW = 24;
  localparam int unsigned DimW = 12;
  localparam logic [16:0] SatLimit = 17'd65280;

  // configuration register indexes
  typedef enum logic [0:0] {REG_WIDTH = 1'b0, REG_HEIGHT = 1'b1} sem_reg_t;

  // classified transaction from front to back
  typedef struct packed {
    logic        emit;
    logic        last;
    logic [8:0]  mask;   // neighbour valid bits, row-major top-left first
    logic [23:0] top;    // new right column of the window
    logic [23:0] mid;
    logic [23:0] bot;
  } sem_cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } sem_res_t;
endpackage

// ===== design/sem_ram.sv =====
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module sem_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== design/sem_front.sv =====
// Front end: position tracking, line stores, classification into commands.
// Depends on sem_pkg and sem_ram.
module sem_front import sem_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [DimW-1:0] eff_w,
  input  logic [DimW-1:0] eff_h,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            kind,
  input  logic [PixW-1:0] pix_in,
  output logic            cmd_valid,
  output sem_cmd_t        cmd,
  input  logic            cmd_take
);
  localparam int unsigned AW = $clog2(MAX_WIDTH);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_HOLD} state_t;
  state_t state_r;

  logic [AW-1:0]   col_r;
  logic [DimW-1:0] row_r;
  logic            done_r;
  logic            kind_r;
  logic [PixW-1:0] pix_r;
  logic [PixW-1:0] old_q, new_q;
  sem_cmd_t        cmd_r;
  logic            cmd_v_r;

  logic accept;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // line stores: read in IDLE accept, written in READ unless a flush is ignored after the frame
  logic wr;
  assign wr = (state_r == S_READ) && !(done_r && kind_r);

  sem_ram #(.WIDTH(PixW), .DEPTH(MAX_WIDTH)) u_old (
    .clk, .we(wr), .waddr(col_r), .wdata(new_q),
    .re(accept), .raddr(col_r), .rdata(old_q));
  sem_ram #(.WIDTH(PixW), .DEPTH(MAX_WIDTH)) u_new (
    .clk, .we(wr), .waddr(col_r), .wdata(pix_r),
    .re(accept), .raddr(col_r), .rdata(new_q));

  // centre position and classification
  logic [DimW:0]   cr;
  logic [DimW-1:0] cc;
  logic            in_frame, last;
  logic [DimW-1:0] colx;
  logic [8:0]      mask;
  logic [DimW:0]   ry;
  logic [DimW:0]   cx;
  assign colx = DimW'(col_r);

  always_comb begin
    if (colx == '0) begin
      cr = {1'b0, row_r} - (DimW+1)'(2);
      cc = eff_w - DimW'(1);
    end else begin
      cr = {1'b0, row_r} - (DimW+1)'(1);
      cc = colx - DimW'(1);
    end
    in_frame = !cr[DimW] && (cr[DimW-1:0] < eff_h);
    last = (cr[DimW-1:0] == eff_h - DimW'(1)) && (cc == eff_w - DimW'(1));
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ry = {1'b0, cr[DimW-1:0]} + (DimW+1)'(r);  // y+1
        cx = {1'b0, cc} + (DimW+1)'(c);            // x+1
        mask[r*3+c] = (ry != '0) && (ry <= {1'b0, eff_h}) &&
                      (cx != '0) && (cx <= {1'b0, eff_w});
      end
    end
  end

  logic [AW-1:0] col_inc;
  assign col_inc = col_r + AW'(1);

  assign cmd_valid = cmd_v_r;
  assign cmd = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      done_r  <= 1'b0;
      cmd_v_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r  <= kind;
            pix_r   <= kind ? '0 : pix_in;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (done_r && kind_r) begin
            state_r <= S_IDLE;
          end else begin
            done_r        <= 1'b0;
            cmd_r.emit    <= in_frame;
            cmd_r.last    <= in_frame && last;
            cmd_r.mask    <= mask;
            cmd_r.top     <= old_q;
            cmd_r.mid     <= new_q;
            cmd_r.bot     <= pix_r;
            cmd_v_r       <= 1'b1;
            state_r       <= S_HOLD;
            if (in_frame && last) begin
              done_r <= 1'b1;
              col_r  <= '0;
              row_r  <= '0;
            end else if ((colx + DimW'(1)) >= eff_w) begin
              col_r <= '0;
              row_r <= row_r + DimW'(1);
            end else begin
              col_r <= col_inc;
            end
          end
        end
        S_HOLD: begin
          if (cmd_take) begin
            cmd_v_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/sem_back.sv =====
// Back end: 3x3 window, Sobel gradients, bit-serial rounded square root.
// Depends on sem_pkg.
module sem_back import sem_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cmd_valid,
  input  sem_cmd_t cmd,
  output logic     cmd_take,
  output logic     res_valid,
  output sem_res_t res,
  input  logic     res_take
);
  typedef enum logic [1:0] {B_IDLE, B_GRAD, B_ROOT, B_OUT} state_t;
  state_t state_r;

  logic [PixW-1:0] win_r [9];
  logic [8:0]      mask_r;
  logic            last_r;
  logic [16:0]     s_r [3];
  logic [7:0]      n_r [3];
  logic [2:0]      bit_r;
  sem_res_t        res_d;

  assign cmd_take  = (state_r == B_IDLE) && cmd_valid;
  assign res_valid = (state_r == B_OUT);
  assign res       = res_d;

  // gradients per colour from the masked window
  logic [16:0] s_c [3];
  always_comb begin
    logic signed [11:0] v [9];
    logic signed [11:0] gx, gy;
    logic signed [23:0] gx_w, gy_w;
    logic [23:0] sq;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++)
        v[k] = mask_r[k] ? 12'($unsigned(win_r[k][16-8*ch +: 8])) : 12'sd0;
      gx = (v[2] - v[0]) + 12'sd2 * (v[5] - v[3]) + (v[8] - v[6]);
      gy = (v[6] - v[0]) + 12'sd2 * (v[7] - v[1]) + (v[8] - v[2]);
      gx_w = 24'(gx);
      gy_w = 24'(gy);
      sq = $unsigned(gx_w * gx_w) + $unsigned(gy_w * gy_w);
      s_c[ch] = (sq > 24'(SatLimit)) ? 17'h1FFFF : sq[16:0];
    end
  end

  // one root bit per cycle for all colours
  logic [7:0] n_try [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) n_try[ch] = n_r[ch] | (8'd1 << bit_r);
  end

  function automatic logic [7:0] fin(logic [16:0] s, logic [7:0] n);
    logic [16:0] nn;
    nn = 17'(n) * 17'(n) + 17'(n);
    if (s > 17'(SatLimit)) return 8'd255;
    return (s > nn) ? n + 8'd1 : n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      state_r <= B_IDLE;
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (cmd_valid) begin
            for (int r = 0; r < 3; r++) begin
              win_r[r*3]   <= win_r[r*3+1];
              win_r[r*3+1] <= win_r[r*3+2];
            end
            win_r[2] <= cmd.top;
            win_r[5] <= cmd.mid;
            win_r[8] <= cmd.bot;
            mask_r   <= cmd.mask;
            last_r   <= cmd.last;
            state_r  <= cmd.emit ? B_GRAD : B_IDLE;
          end
        end
        B_GRAD: begin
          for (int ch = 0; ch < 3; ch++) begin
            s_r[ch] <= s_c[ch];
            n_r[ch] <= '0;
          end
          bit_r   <= 3'd7;
          state_r <= B_ROOT;
        end
        B_ROOT: begin
          for (int ch = 0; ch < 3; ch++)
            if (17'(n_try[ch]) * 17'(n_try[ch]) <= s_r[ch]) n_r[ch] <= n_try[ch];
          if (bit_r == 3'd0) state_r <= B_OUT;
          bit_r <= bit_r - 3'd1;
        end
        B_OUT: begin
          if (res_take) state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // final rounding from the held root and energy registers
  always_comb begin
    res_d.red   = fin(s_r[0], n_r[0]);
    res_d.green = fin(s_r[1], n_r[1]);
    res_d.blue  = fin(s_r[2], n_r[2]);
    res_d.last  = last_r;
  end
endmodule

// ===== design/sobel_edge_magnitude_rgb_unit.sv =====
// Top level of the RGB Sobel edge magnitude unit.
// Depends on sem_pkg, sem_front, sem_back, sem_ram.
//
// Channel  | Direction | Handshake
// in_      | input     | in_valid / in_stall
// out_     | output    | out_valid / out_stall
// cfg_     | input     | cfg_we, no wait
//
// Front takes one transaction at a time: line store read, classify, hand off.
// Back works through a transaction with a result in steps: window shift, gradient,
// eight root bits, output; it is the limit on throughput.
// Reset and every configuration write restart the frame at position zero.
// Output stall holds the back; the front then holds its command and stalls input.
module sobel_edge_magnitude_rgb_unit import sem_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [DimW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_kind,
  input  logic [7:0]      in_red_in,
  input  logic [7:0]      in_green_in,
  input  logic [7:0]      in_blue_in,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_red_edge,
  output logic [7:0]      out_green_edge,
  output logic [7:0]      out_blue_edge,
  output logic            out_frame_last
);
  logic [DimW-1:0] width_r, height_r, eff_w, eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DimW'(640);
      height_r <= DimW'(480);
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) width_r <= cfg_data;
      if (cfg_index == REG_HEIGHT) height_r <= cfg_data;
    end
  end

  // effective frame size
  always_comb begin
    eff_w = (width_r == '0) ? DimW'(1) : width_r;
    if (32'(eff_w) > MAX_WIDTH) eff_w = DimW'(MAX_WIDTH);
    eff_h = (height_r == '0) ? DimW'(1) : height_r;
  end

  logic     cmd_valid, cmd_take;
  sem_cmd_t cmd;
  sem_res_t res;

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst_n, .cfg_we, .eff_w, .eff_h,
    .in_valid, .in_stall, .kind(in_kind),
    .pix_in({in_red_in, in_green_in, in_blue_in}),
    .cmd_valid, .cmd, .cmd_take);

  sem_back u_back (
    .clk, .rst_n, .cfg_we, .cmd_valid, .cmd, .cmd_take,
    .res_valid(out_valid), .res, .res_take(!out_stall));

  assign out_red_edge   = res.red;
  assign out_green_edge = res.green;
  assign out_blue_edge  = res.blue;
  assign out_frame_last = res.last;
endmodule

// ===== design/sem_checker.sv =====
// Port-level checker for the Sobel edge magnitude unit, bound to the top level.
// Depends on sobel_edge_magnitude_rgb_unit.
module sem_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red_edge
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_edge))
    else $error("result dropped or changed under stall");
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("back-to-back results");
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted without processing gap");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear handshake");
endmodule

bind sobel_edge_magnitude_rgb_unit sem_checker u_sem_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_red_edge);

// ===== tb/tb_top.sv =====
// Self-checking testbench for sobel_edge_magnitude_rgb_unit: random and directed frames
// with a transaction-level software predictor. Depends on sem_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_top;
  import sem_pkg::*;

  localparam int MaxWidth = 2048;
  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 40;

  typedef enum bit {KIND_PIXEL = 1'b0, KIND_FLUSH = 1'b1} item_kind_e;

  typedef struct {
    item_kind_e kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [DimW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic [7:0] in_red_in = '0;
  logic [7:0] in_green_in = '0;
  logic [7:0] in_blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red_edge;
  logic [7:0] out_green_edge;
  logic [7:0] out_blue_edge;
  logic out_frame_last;

  sobel_edge_magnitude_rgb_unit dut (.*);

  always #10 clk = ~clk;

  // pixel stream waiting for the driver, and edge results predicted but not yet seen
  pixel_item_t pixel_fifo[$];
  sem_res_t pending_edges[$];
  int items_left = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int result_count = 0;
  int frame_count = 0;
  int item_count = 0;
  int cycle_count = 0;

  // predictor state
  logic [11:0] width_reg = 12'd640;
  logic [11:0] height_reg = 12'd480;
  logic [23:0] older_line[MaxWidth];
  logic [23:0] newer_line[MaxWidth];
  logic [23:0] win[3][3];
  int col_pos = 0;
  int row_pos = 0;
  bit frame_done = 0;

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return width_reg;
  endfunction

  function automatic int eff_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  // rounded square root of the gradient energy, saturated at 255
  function automatic logic [7:0] rounded_root(int unsigned s);
    int unsigned n;
    n = 0;
    if (s > 65280) return 8'd255;
    for (int b = 128; b > 0; b = b >> 1)
      if ((n + b) * (n + b) <= s) n = n + b;
    if (s > n * n + n) n++;
    return n[7:0];
  endfunction

  function automatic logic [7:0] grad_mag(int v[3][3]);
    int gx;
    int gy;
    gx = (v[0][2] - v[0][0]) + 2 * (v[1][2] - v[1][0]) + (v[2][2] - v[2][0]);
    gy = (v[2][0] - v[0][0]) + 2 * (v[2][1] - v[0][1]) + (v[2][2] - v[0][2]);
    return rounded_root(gx * gx + gy * gy);
  endfunction

  // advance the window by one accepted transaction; queue a result if one is due
  function automatic void predict_edge(bit kind, logic [23:0] pix_in);
    int w;
    int h;
    int ic;
    int ir;
    int cr;
    int cc;
    int y;
    int x;
    int v[3][3];
    logic [23:0] pix;
    logic [7:0] mag[3];
    sem_res_t res;
    w = eff_width();
    h = eff_height();
    if (frame_done) begin
      if (kind == KIND_FLUSH) return;
      frame_done = 0;
    end
    pix = (kind == KIND_FLUSH) ? 24'd0 : pix_in;
    ic = (col_pos >= w) ? w - 1 : col_pos;
    ir = row_pos;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = older_line[ic];
    win[1][2] = newer_line[ic];
    win[2][2] = pix;
    older_line[ic] = newer_line[ic];
    newer_line[ic] = pix;
    if (ic == 0) begin
      cr = ir - 2;
      cc = w - 1;
    end else begin
      cr = ir - 1;
      cc = ic - 1;
    end
    if (cr >= 0 && cr < h) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++) begin
            y = cr - 1 + r;
            x = cc - 1 + c;
            v[r][c] = (y >= 0 && y < h && x >= 0 && x < w) ?
                      int'(win[r][c][16 - 8 * ch +: 8]) : 0;
          end
        mag[ch] = grad_mag(v);
      end
      res.red = mag[0];
      res.green = mag[1];
      res.blue = mag[2];
      res.last = (cr == h - 1) && (cc == w - 1);
      pending_edges.push_back(res);
      if (res.last) begin
        frame_done = 1;
        col_pos = 0;
        row_pos = 0;
        return;
      end
    end
    ic++;
    if (ic >= w) begin
      ic = 0;
      ir = (ir + 1) & 12'hfff;
    end
    col_pos = ic;
    row_pos = ir;
  endfunction

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // driver: one transaction per handshake, random gaps
  pixel_item_t next_item;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_edge(in_kind, {in_red_in, in_green_in, in_blue_in});
        items_left--;
        item_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pixel_fifo.pop_front();
          in_valid <= 1'b1;
          in_kind <= next_item.kind;
          in_red_in <= next_item.red;
          in_green_in <= next_item.green;
          in_blue_in <= next_item.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result against the oldest prediction
  sem_res_t want;
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (pending_edges.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = pending_edges.pop_front();
        if (out_red_edge !== want.red)
          report($sformatf("red %0d, want %0d", out_red_edge, want.red));
        if (out_green_edge !== want.green)
          report($sformatf("green %0d, want %0d", out_green_edge, want.green));
        if (out_blue_edge !== want.blue)
          report($sformatf("blue %0d, want %0d", out_blue_edge, want.blue));
        if (out_frame_last !== want.last)
          report($sformatf("frame_last %0b, want %0b", out_frame_last, want.last));
        if (want.last) frame_count++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] rand_level();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_item(item_kind_e kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_item_t it;
    it.kind = kind;
    it.red = r;
    it.green = g;
    it.blue = b;
    pixel_fifo.push_back(it);
    items_left++;
  endtask

  task automatic push_random(item_kind_e kind);
    push_item(kind, rand_level(), rand_level(), rand_level());
  endtask

  // wait until every transaction is in and every result is out, then let the pipe settle
  task automatic drain();
    while (items_left != 0 || pending_edges.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(sem_reg_t idx, logic [11:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_WIDTH) width_reg = value;
    else height_reg = value;
    col_pos = 0;
    row_pos = 0;
    frame_done = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one frame of w x h pixels plus the flush tail; sometimes broken or padded with noise
  task automatic random_frame();
    int w;
    int h;
    int n;
    w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    h = $urandom_range(8, 1);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    n = w * h;
    if ($urandom_range(9) == 0) n = $urandom_range(n);
    for (int i = 0; i < n; i++) begin
      push_random(($urandom_range(19) == 0) ? KIND_FLUSH : KIND_PIXEL);
    end
    for (int i = 0; i < w + 1; i++) push_random(KIND_FLUSH);
    // ignored flushes after the frame, and sometimes a pixel starting a new frame
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1)) push_random(KIND_FLUSH);
      push_random(KIND_PIXEL);
    end
    drain();
  endtask

  task automatic random_phase(int idle_pct, int stall_pct, int quota);
    int start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = item_count;
    while (item_count - start < quota) random_frame();
  endtask

  initial begin
    for (int i = 0; i < MaxWidth; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // single pixel frame, ignored flushes after it, then a new frame
    write_reg(REG_WIDTH, 12'd1);
    write_reg(REG_HEIGHT, 12'd1);
    push_item(KIND_PIXEL, 8'd255, 8'd0, 8'd255);
    push_item(KIND_FLUSH, 8'd255, 8'd255, 8'd255);
    push_item(KIND_FLUSH, 8'd0, 8'd0, 8'd0);
    push_item(KIND_FLUSH, 8'd255, 8'd255, 8'd255);
    push_item(KIND_PIXEL, 8'd0, 8'd255, 8'd0);
    push_item(KIND_FLUSH, 8'd0, 8'd0, 8'd0);
    push_item(KIND_FLUSH, 8'd0, 8'd0, 8'd0);
    drain();

    // zero sizes act as one
    write_reg(REG_WIDTH, 12'd0);
    write_reg(REG_HEIGHT, 12'd0);
    push_item(KIND_PIXEL, 8'd128, 8'd1, 8'd254);
    push_item(KIND_FLUSH, 8'd0, 8'd0, 8'd0);
    push_item(KIND_FLUSH, 8'd0, 8'd0, 8'd0);
    drain();

    // 3x3 checkerboard saturates; pixels past the frame end act as flushes
    write_reg(REG_WIDTH, 12'd3);
    write_reg(REG_HEIGHT, 12'd3);
    for (int i = 0; i < 9; i++)
      if (i % 2 == 0) push_item(KIND_PIXEL, 8'd255, 8'd255, 8'd255);
      else push_item(KIND_PIXEL, 8'd0, 8'd0, 8'd0);
    push_item(KIND_PIXEL, 8'd255, 8'd255, 8'd255);
    push_item(KIND_PIXEL, 8'd255, 8'd0, 8'd255);
    push_item(KIND_FLUSH, 8'd0, 8'd0, 8'd0);
    push_item(KIND_FLUSH, 8'd0, 8'd0, 8'd0);
    drain();

    // widest setting clamps to the line store depth; only the start of row 0 is fed
    write_reg(REG_WIDTH, 12'hfff);
    write_reg(REG_HEIGHT, 12'd2);
    repeat (40) push_random(KIND_PIXEL);
    drain();

    // tallest frame, only its top rows fed
    write_reg(REG_WIDTH, 12'd2);
    write_reg(REG_HEIGHT, 12'hfff);
    repeat (12) push_random(KIND_PIXEL);
    drain();

    random_phase(0, 0, 330);
    random_phase(56, 0, 330);
    random_phase(0, 56, 330);
    random_phase(21, 21, 340);
    drain();

    $display("Ran %0d transactions, %0d results, %0d complete frames,", item_count,
             result_count, frame_count);
    $display("frames from 1x1 to 40x8 plus clamped sizes, under four idle/stall mixes.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
